>>> hdl/rfcd_pkg.sv
// Shared types and constants for the run-length frame chunk decoder.
package rfcd_pkg;

  // Widest line that the frame store stride may take.
  localparam int MaxLineWidth = 1024;

  localparam int CfgW   = 11;            // width of each configuration register
  localparam int AddrW  = 20;            // frame store address width
  localparam int LimitW = 2 * CfgW;      // width of line width times frame height
  localparam int PaddrW = 3;             // two registers at byte addresses 0 and 4

  localparam logic [CfgW-1:0]   LineWidthRst   = CfgW'(320);
  localparam logic [CfgW-1:0]   FrameHeightRst = CfgW'(200);

  // Register index codes, taken from paddr[2].
  localparam logic RegLineWidth   = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  typedef logic [AddrW-1:0] addr_t;

  // One input item held in the input register.
  typedef struct packed {
    logic       mode;
    logic       chunk_start;
    logic [7:0] data_byte;
  } item_t;

  // Configuration as seen by the parser.
  typedef struct packed {
    logic [CfgW-1:0]   eff_width;
    logic [CfgW-1:0]   frame_height;
    logic [LimitW-1:0] frame_limit;
  } cfg_t;

endpackage

>>> hdl/rfcd_in_if.sv
// Input channel: one chunk body byte per item.
interface rfcd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       chunk_start;
  logic [7:0] data_byte;

  modport source (output valid, mode, chunk_start, data_byte, input ready);
  modport sink   (input valid, mode, chunk_start, data_byte, output ready);
endinterface

>>> hdl/rfcd_out_if.sv
// Output channel: one pixel-run write command per item.
interface rfcd_out_if;
  logic                 valid;
  logic                 ready;
  rfcd_pkg::addr_t      run_address;
  logic [7:0]           run_length;
  logic [7:0]           run_value;
  logic                 outside_frame;
  logic                 chunk_done;

  modport source (output valid, run_address, run_length, run_value, outside_frame, chunk_done,
                  input ready);
  modport sink   (input valid, run_address, run_length, run_value, outside_frame, chunk_done,
                  output ready);
endinterface

>>> hdl/rle_frame_chunk_decoder.sv
// Top level of the run-length frame chunk decoder: input register, parser, registers.
//
//   Port       Direction  Handshake      Item
//   in_i       sink       valid/ready    mode, chunk_start, data_byte
//   run_o      source     valid/ready    run_address, run_length, run_value,
//                                        outside_frame, chunk_done
//   APB        slave      psel/penable   line_width (0x0), frame_height (0x4)
//
// One byte is taken every cycle while the result register is not stalled; a result
// leaves through the input register and then the result register.
// The parser updates its state once per byte.
// Reset is asynchronous and active low; it returns the parser to idle.
// A stalled result holds the parser, and the input register then fills.
module rle_frame_chunk_decoder import rfcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  rfcd_in_if.sink           in_i,
  rfcd_out_if.source        run_o
);

  cfg_t  cfg;
  logic  take;
  logic  in_valid_q;
  item_t item_q;

  rfcd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register: refilled whenever it is empty or its item moves on.
  assign in_i.ready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.mode        <= in_i.mode;
      item_q.chunk_start <= in_i.chunk_start;
      item_q.data_byte   <= in_i.data_byte;
    end
  end

  rfcd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (item_q),
    .cfg_i        (cfg),
    .take_o       (take),
    .run_o        (run_o)
  );

endmodule

>>> hdl/rfcd_cfg.sv
// APB configuration registers and the derived frame size limit.
module rfcd_cfg import rfcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [CfgW-1:0]   line_width_q;
  logic [CfgW-1:0]   frame_height_q;
  logic [LimitW-1:0] frame_limit_q;
  logic [CfgW-1:0]   eff_width;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Lines wider than the maximum stride are clamped.
  always_comb begin
    if (32'(line_width_q) > MaxLineWidth) begin
      eff_width = CfgW'(MaxLineWidth);
    end else begin
      eff_width = line_width_q;
    end
  end

  // Register writes; the frame limit follows in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LineWidthRst;
      frame_height_q <= FrameHeightRst;
      frame_limit_q  <= LimitW'(LineWidthRst) * LimitW'(FrameHeightRst);
    end else begin
      if (wr_en) begin
        unique case (paddr[2])
          RegLineWidth:   line_width_q   <= pwdata[CfgW-1:0];
          RegFrameHeight: frame_height_q <= pwdata[CfgW-1:0];
          default: ;
        endcase
      end
      frame_limit_q <= LimitW'(eff_width) * LimitW'(frame_height_q);
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[2])
      RegLineWidth:   prdata = 32'(line_width_q);
      RegFrameHeight: prdata = 32'(frame_height_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.eff_width    = eff_width;
  assign cfg_o.frame_height = frame_height_q;
  assign cfg_o.frame_limit  = frame_limit_q;

endmodule

>>> hdl/rfcd_core.sv
// Chunk parser, one byte per cycle unless the result stalls; result register.
module rfcd_core import rfcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  input  cfg_t        cfg_i,
  output logic        take_o,
  rfcd_out_if.source  run_o
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_PKT_COUNT,
    PH_KEY_CTRL,
    PH_DELTA_SKIP,
    PH_DELTA_CTRL,
    PH_LITERAL,
    PH_REPEAT_VAL,
    PH_SKIP_LO,
    PH_SKIP_HI,
    PH_COUNT_LO,
    PH_COUNT_HI
  } phase_e;

  phase_e      phase_q, phase_d, cur_ph, ctrl_ph;
  logic        kind_q, kind_d, cur_kind;
  logic [15:0] lines_q, lines_d, cur_lines, lines_end;
  logic [7:0]  pk_q, pk_d, cur_pk, pk_end;
  logic [7:0]  lit_q, lit_d, cur_lit, lit_dec;
  addr_t       ls_q, ls_d, cur_ls, ls_end;
  addr_t       wa_q, wa_d, cur_wa;
  logic [7:0]  hdr_q, hdr_d;
  logic [7:0]  b;
  logic        early_done;
  logic        last_line, last_pkt;
  logic [15:0] hdr_word;
  logic [15+CfgW:0] skip_prod;

  logic        end_pkt, end_ln, fin, bare_now, bare_on_fin, run_req;
  addr_t       res_addr;
  logic [7:0]  res_len, res_val;
  logic        res_valid, res_done, res_outside;
  logic        step;

  logic        out_valid_q;
  addr_t       out_addr_q;
  logic [7:0]  out_len_q, out_val_q;
  logic        out_outside_q, out_done_q;

  assign b      = item_i.data_byte;
  assign take_o = !out_valid_q || run_o.ready;
  assign step   = take_o && item_valid_i;

  // Chunk start overrides the held state before the byte is parsed.
  always_comb begin
    cur_kind   = kind_q;
    cur_ph     = phase_q;
    cur_lines  = lines_q;
    cur_pk     = pk_q;
    cur_lit    = lit_q;
    cur_ls     = ls_q;
    cur_wa     = wa_q;
    early_done = 1'b0;
    if (item_i.chunk_start) begin
      cur_kind = item_i.mode;
      cur_ls   = '0;
      cur_wa   = '0;
      cur_pk   = '0;
      cur_lit  = '0;
      if (item_i.mode) begin
        cur_lines = '0;
        cur_ph    = PH_SKIP_LO;
      end else begin
        cur_lines = 16'(cfg_i.frame_height);
        if (cfg_i.frame_height == '0) begin
          early_done = 1'b1;
          cur_ph     = PH_IDLE;
        end else begin
          cur_ph = PH_PKT_COUNT;
        end
      end
    end
  end

  // Values for the end of a packet or line, and the delta line skip product.
  always_comb begin
    ls_end    = cur_ls + AddrW'(cfg_i.eff_width);
    lines_end = cur_lines - 16'd1;
    last_line = (lines_end == '0);
    pk_end    = cur_pk - 8'd1;
    last_pkt  = (pk_end == '0);
    lit_dec   = cur_lit - 8'd1;
    ctrl_ph   = cur_kind ? PH_DELTA_SKIP : PH_KEY_CTRL;
    hdr_word  = {b, hdr_q};
    skip_prod = (16+CfgW)'(hdr_word) * (16+CfgW)'(cfg_i.eff_width);
  end

  // Parser: next state and the result of this byte.
  always_comb begin
    phase_d     = cur_ph;
    kind_d      = cur_kind;
    lines_d     = cur_lines;
    pk_d        = cur_pk;
    lit_d       = cur_lit;
    ls_d        = cur_ls;
    wa_d        = cur_wa;
    hdr_d       = hdr_q;
    end_pkt     = 1'b0;
    end_ln      = 1'b0;
    fin         = 1'b0;
    bare_now    = 1'b0;
    bare_on_fin = 1'b0;
    run_req     = 1'b0;
    res_len     = '0;

    if (early_done) begin
      bare_now = 1'b1;
    end else begin
      unique case (cur_ph)
        PH_SKIP_LO: begin
          hdr_d   = b;
          phase_d = PH_SKIP_HI;
        end
        PH_SKIP_HI: begin
          ls_d    = skip_prod[AddrW-1:0];
          wa_d    = skip_prod[AddrW-1:0];
          phase_d = PH_COUNT_LO;
        end
        PH_COUNT_LO: begin
          hdr_d   = b;
          phase_d = PH_COUNT_HI;
        end
        PH_COUNT_HI: begin
          // A zero or negative line count means an empty chunk.
          if (hdr_word == '0 || hdr_word[15]) begin
            bare_now = 1'b1;
            phase_d  = PH_IDLE;
          end else begin
            lines_d = hdr_word;
            phase_d = PH_PKT_COUNT;
          end
        end
        PH_PKT_COUNT: begin
          pk_d = b;
          if (b == '0) begin
            end_ln      = 1'b1;
            bare_on_fin = 1'b1;
          end else begin
            phase_d = ctrl_ph;
          end
        end
        PH_KEY_CTRL: begin
          if (b[7]) begin
            lit_d   = 8'd0 - b;
            phase_d = PH_LITERAL;
          end else begin
            lit_d   = b;
            phase_d = PH_REPEAT_VAL;
          end
        end
        PH_DELTA_SKIP: begin
          wa_d    = cur_wa + AddrW'(b);
          phase_d = PH_DELTA_CTRL;
        end
        PH_DELTA_CTRL: begin
          // Negation of 0x80 gives 0x80, a repeat of 128.
          if (b != '0 && !b[7]) begin
            lit_d   = b;
            phase_d = PH_LITERAL;
          end else begin
            lit_d   = 8'd0 - b;
            phase_d = PH_REPEAT_VAL;
          end
        end
        PH_LITERAL: begin
          run_req = 1'b1;
          res_len = 8'd1;
          wa_d    = cur_wa + AddrW'(1);
          lit_d   = lit_dec;
          end_pkt = (lit_dec == '0);
        end
        PH_REPEAT_VAL: begin
          res_len     = cur_lit;
          run_req     = (cur_lit != '0);
          bare_on_fin = (cur_lit == '0);
          wa_d        = cur_wa + AddrW'(cur_lit);
          lit_d       = '0;
          end_pkt     = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    // End of packet, and end of line when the packet was the last one.
    if (end_pkt) begin
      pk_d = pk_end;
      if (last_pkt) begin
        end_ln = 1'b1;
      end else begin
        phase_d = ctrl_ph;
      end
    end
    if (end_ln) begin
      ls_d    = ls_end;
      wa_d    = ls_end;
      lines_d = lines_end;
      if (last_line) begin
        phase_d = PH_IDLE;
        fin     = 1'b1;
      end else begin
        phase_d = PH_PKT_COUNT;
      end
    end

    // Result fields; a bare done marker carries zeros.
    res_valid   = bare_now || run_req || (bare_on_fin && fin);
    res_done    = bare_now || fin;
    res_addr    = run_req ? cur_wa : '0;
    res_val     = run_req ? b : '0;
    if (!run_req) begin
      res_len = '0;
    end
    res_outside = run_req &&
                  ((LimitW'(cur_wa) + LimitW'(res_len)) > cfg_i.frame_limit);
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      kind_q  <= 1'b0;
      lines_q <= '0;
      pk_q    <= '0;
      lit_q   <= '0;
      ls_q    <= '0;
      wa_q    <= '0;
      hdr_q   <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      lines_q <= lines_d;
      pk_q    <= pk_d;
      lit_q   <= lit_d;
      ls_q    <= ls_d;
      wa_q    <= wa_d;
      hdr_q   <= hdr_d;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= item_valid_i && res_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_addr_q    <= res_addr;
      out_len_q     <= res_len;
      out_val_q     <= res_val;
      out_outside_q <= res_outside;
      out_done_q    <= res_done;
    end
  end

  assign run_o.valid         = out_valid_q;
  assign run_o.run_address   = out_addr_q;
  assign run_o.run_length    = out_len_q;
  assign run_o.run_value     = out_val_q;
  assign run_o.outside_frame = out_outside_q;
  assign run_o.chunk_done    = out_done_q;

endmodule

>>> test/rle_frame_chunk_decoder_tb.sv
// Self-checking testbench for the run-length frame chunk decoder.
`timescale 1ns / 1ps

module rle_frame_chunk_decoder_tb import rfcd_pkg::*; ();

  // Parser phases of the decoder as predicted here.
  typedef enum logic [3:0] {
    PhIdle, PhPktCount, PhKeyCtrl, PhDeltaSkip, PhDeltaCtrl, PhLiteral,
    PhRepeatVal, PhSkipLo, PhSkipHi, PhCountLo, PhCountHi
  } phase_e;

  // One pixel-run write command as it leaves the block.
  typedef struct packed {
    addr_t      run_address;
    logic [7:0] run_length;
    logic [7:0] run_value;
    logic       outside_frame;
    logic       chunk_done;
  } run_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  rfcd_in_if  bytes_if ();
  rfcd_out_if runs_if ();

  rle_frame_chunk_decoder DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (bytes_if),
    .run_o   (runs_if)
  );

  always #5 clk_i = ~clk_i;

  // Bytes waiting to be offered and runs waiting to arrive.
  item_t byte_queue [$];
  run_t  runs_due [$];
  item_t next_byte;

  int fail_count     = 0;
  int bytes_made     = 0;
  int bytes_accepted = 0;
  int runs_checked   = 0;
  int dones_seen     = 0;
  int outside_seen   = 0;

  // Flow control knobs shared by the stimulus and the two drivers.
  int   idle_pct       = 0;
  int   in_gap         = 0;
  int   out_gap        = 0;
  int   hold_left      = 0;
  bit   long_hold_req  = 1'b0;
  bit   long_hold_done = 1'b0;
  logic in_fired       = 1'b0;

  // Chunk under construction: the next body byte carries the start flag.
  bit   start_next = 1'b0;
  logic chunk_mode = 1'b0;

  // Predicted configuration and parser state.
  logic [CfgW-1:0] cfg_width     = LineWidthRst;
  logic [CfgW-1:0] cfg_height    = FrameHeightRst;
  phase_e          dec_phase     = PhIdle;
  logic            is_delta      = 1'b0;
  logic [15:0]     rows_left     = '0;
  logic [7:0]      packets_to_go = '0;
  logic [7:0]      count_left    = '0;
  addr_t           row_base      = '0;
  addr_t           wr_ptr        = '0;
  logic [7:0]      hdr_lo        = '0;

  // Line stride, clamped to the widest line the block supports.
  function automatic int unsigned stride();
    return (cfg_width > MaxLineWidth) ? MaxLineWidth : int'(cfg_width);
  endfunction

  function automatic void push_run(addr_t a, logic [7:0] len, logic [7:0] val, logic done);
    run_t        r;
    int unsigned lim;
    lim             = stride() * cfg_height;
    r.run_address   = a;
    r.run_length    = len;
    r.run_value     = val;
    r.outside_frame = (len != 0) && ((32'(a) + 32'(len)) > lim);
    r.chunk_done    = done;
    runs_due.push_back(r);
  endfunction

  // A done marker with every other field zero; the parser goes idle.
  function automatic void push_marker();
    run_t r;
    r            = '0;
    r.chunk_done = 1'b1;
    dec_phase    = PhIdle;
    runs_due.push_back(r);
  endfunction

  // Moves to the next line; true when that was the last line of the chunk.
  function automatic bit close_row();
    row_base  = row_base + addr_t'(stride());
    wr_ptr    = row_base;
    rows_left = rows_left - 16'd1;
    if (rows_left == 0) begin
      dec_phase = PhIdle;
      return 1'b1;
    end
    dec_phase = PhPktCount;
    return 1'b0;
  endfunction

  function automatic bit close_packet();
    packets_to_go = packets_to_go - 8'd1;
    if (packets_to_go == 0) return close_row();
    dec_phase = is_delta ? PhDeltaSkip : PhKeyCtrl;
    return 1'b0;
  endfunction

  // Advances the predicted parser by one accepted byte and queues any run it causes.
  function automatic void decode_byte(logic mode, logic start, logic [7:0] b);
    addr_t       a;
    logic [7:0]  n;
    logic [15:0] word;
    bit          done;
    if (start) begin
      is_delta      = mode;
      row_base      = '0;
      wr_ptr        = '0;
      packets_to_go = '0;
      count_left    = '0;
      if (mode) begin
        rows_left = '0;
        dec_phase = PhSkipLo;
      end else begin
        rows_left = 16'(cfg_height);
        if (rows_left == 0) begin
          push_marker();
          return;
        end
        dec_phase = PhPktCount;
      end
    end
    case (dec_phase)
      PhSkipLo: begin
        hdr_lo    = b;
        dec_phase = PhSkipHi;
      end
      PhSkipHi: begin
        row_base  = addr_t'(32'({b, hdr_lo}) * stride());
        wr_ptr    = row_base;
        dec_phase = PhCountLo;
      end
      PhCountLo: begin
        hdr_lo    = b;
        dec_phase = PhCountHi;
      end
      PhCountHi: begin
        word = {b, hdr_lo};
        if (word == 0 || word[15]) begin
          push_marker();
        end else begin
          rows_left = word;
          dec_phase = PhPktCount;
        end
      end
      PhPktCount: begin
        packets_to_go = b;
        if (b == 0) begin
          if (close_row()) push_marker();
        end else begin
          dec_phase = is_delta ? PhDeltaSkip : PhKeyCtrl;
        end
      end
      PhKeyCtrl: begin
        if (b[7]) begin
          count_left = 8'd0 - b;
          dec_phase  = PhLiteral;
        end else begin
          count_left = b;
          dec_phase  = PhRepeatVal;
        end
      end
      PhDeltaSkip: begin
        wr_ptr    = wr_ptr + addr_t'(b);
        dec_phase = PhDeltaCtrl;
      end
      PhDeltaCtrl: begin
        // Positive means literal; zero and negative mean repeat, -128 giving 128.
        if (b != 0 && !b[7]) begin
          count_left = b;
          dec_phase  = PhLiteral;
        end else begin
          count_left = 8'd0 - b;
          dec_phase  = PhRepeatVal;
        end
      end
      PhLiteral: begin
        a          = wr_ptr;
        wr_ptr     = wr_ptr + 20'd1;
        count_left = count_left - 8'd1;
        done       = 1'b0;
        if (count_left == 0) done = close_packet();
        push_run(a, 8'd1, b, done);
      end
      PhRepeatVal: begin
        n          = count_left;
        a          = wr_ptr;
        wr_ptr     = wr_ptr + addr_t'(n);
        count_left = '0;
        done       = close_packet();
        // An empty repeat only shows when it finishes the chunk.
        if (n == 0) begin
          if (done) push_marker();
        end else begin
          push_run(a, n, b, done);
        end
      end
      default: dec_phase = PhIdle;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Byte sender: offers queued bytes, with random bursts of idle cycles.
  always @(negedge clk_i) begin
    if (rst_ni && (!bytes_if.valid || in_fired)) begin
      if (in_gap != 0) begin
        bytes_if.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        bytes_if.valid <= 1'b0;
        in_gap <= $urandom_range(0, 8);
      end else if (byte_queue.size() != 0) begin
        next_byte = byte_queue.pop_front();
        bytes_if.valid       <= 1'b1;
        bytes_if.mode        <= next_byte.mode;
        bytes_if.chunk_start <= next_byte.chunk_start;
        bytes_if.data_byte   <= next_byte.data_byte;
      end else begin
        bytes_if.valid <= 1'b0;
      end
    end
  end

  // Run receiver: random stall bursts, and one long hold-off when asked for.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        runs_if.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (long_hold_req && !long_hold_done) begin
        runs_if.ready <= 1'b0;
        hold_left <= 120;
        long_hold_done <= 1'b1;
      end else if (out_gap != 0) begin
        runs_if.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        runs_if.ready <= 1'b0;
        out_gap <= $urandom_range(0, 8);
      end else begin
        runs_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each accepted byte and checks each accepted run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fired <= bytes_if.valid && bytes_if.ready;
      if (bytes_if.valid && bytes_if.ready) begin
        decode_byte(bytes_if.mode, bytes_if.chunk_start, bytes_if.data_byte);
        bytes_accepted++;
      end
      if (runs_if.valid && runs_if.ready) begin
        if (runs_due.size() == 0) begin
          $error("run with none expected: address %0d, length %0d, value %0d",
                 runs_if.run_address, runs_if.run_length, runs_if.run_value);
          fail_count++;
        end else begin
          run_t want;
          want = runs_due.pop_front();
          check_field("run_address", 32'(want.run_address), 32'(runs_if.run_address));
          check_field("run_length", 32'(want.run_length), 32'(runs_if.run_length));
          check_field("run_value", 32'(want.run_value), 32'(runs_if.run_value));
          check_field("outside_frame", 32'(want.outside_frame),
                      32'(runs_if.outside_frame));
          check_field("chunk_done", 32'(want.chunk_done), 32'(runs_if.chunk_done));
          runs_checked++;
        end
        if (runs_if.chunk_done === 1'b1) dones_seen++;
        if (runs_if.outside_frame === 1'b1) outside_seen++;
      end
    end
  end

  // Writes one register, with noise in the unused upper bits, and reads it back.
  task automatic reg_write(logic idx, logic [CfgW-1:0] val);
    logic [31:0] word;
    word = $urandom;
    word[CfgW-1:0] = val;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("register read-back", 32'(val), prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == RegLineWidth) cfg_width = val;
    else cfg_height = val;
  endtask

  task automatic put(logic m, logic s, logic [7:0] b);
    item_t it;
    it.mode        = m;
    it.chunk_start = s;
    it.data_byte   = b;
    byte_queue.push_back(it);
    bytes_made++;
  endtask

  task automatic begin_chunk(logic m);
    start_next = 1'b1;
    chunk_mode = m;
  endtask

  // Body bytes carry a random mode bit, which only counts with a chunk start.
  task automatic put_body(logic [7:0] b);
    put(start_next ? chunk_mode : 1'($urandom), start_next, b);
    start_next = 1'b0;
  endtask

  task automatic make_packet(bit delta);
    int n;
    if (delta) put_body(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)));
    if ($urandom_range(0, 1) == 1) begin
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(1, delta ? 127 : 128)
                                       : $urandom_range(1, 4);
      put_body(delta ? 8'(n) : 8'(-n));
      repeat (n) put_body(8'($urandom));
    end else begin
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, delta ? 128 : 127);
      put_body(delta ? 8'(-n) : 8'(n));
      put_body(8'($urandom));
    end
  endtask

  task automatic make_line(bit delta);
    int pk;
    pk = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
    put_body(8'(pk));
    repeat (pk) make_packet(delta);
  endtask

  // Key chunks on tall frames are cut short and abandoned by the next start.
  task automatic make_key_chunk();
    int rows;
    begin_chunk(1'b0);
    if (cfg_height == 0) begin
      put_body(8'($urandom));
    end else begin
      rows = (cfg_height > 5) ? $urandom_range(1, 5) : int'(cfg_height);
      repeat (rows) make_line(1'b0);
    end
  endtask

  task automatic make_delta_chunk();
    int skip;
    int rows;
    begin_chunk(1'b1);
    skip = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
    put_body(8'(skip));
    put_body(8'(skip >> 8));
    case ($urandom_range(0, 7))
      0: rows = 0;
      1: rows = 32'h8000 | $urandom_range(0, 32767);
      default: rows = $urandom_range(1, 4);
    endcase
    put_body(8'(rows));
    put_body(8'(rows >> 8));
    if (rows >= 1 && rows <= 4) repeat (rows) make_line(1'b1);
  endtask

  task automatic make_noise();
    repeat ($urandom_range(1, 6)) begin
      put(1'($urandom), $urandom_range(0, 3) == 0, 8'($urandom));
    end
  endtask

  task automatic make_broken();
    begin_chunk(1'($urandom));
    repeat ($urandom_range(1, 8)) put_body(8'($urandom));
  endtask

  // Mostly well-formed chunks with random content, some noise and cut-off chunks.
  task automatic fill_random(int n_bytes);
    int goal;
    goal = bytes_made + n_bytes;
    while (bytes_made < goal) begin
      case ($urandom_range(0, 9))
        0: make_noise();
        1: make_broken();
        2, 3, 4, 5: make_key_chunk();
        default: make_delta_chunk();
      endcase
    end
  endtask

  // Waits until every byte is taken and every run has arrived, then for the latency.
  task automatic wait_drained();
    while (bytes_accepted != bytes_made || runs_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(logic [CfgW-1:0] w, logic [CfgW-1:0] h, int idle, bit hold);
    reg_write(RegLineWidth, w);
    reg_write(RegFrameHeight, h);
    idle_pct      = idle;
    long_hold_req = hold;
    fill_random(150);
    wait_drained();
  endtask

  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    bytes_if.valid       = 1'b0;
    bytes_if.mode        = 1'b0;
    bytes_if.chunk_start = 1'b0;
    bytes_if.data_byte   = '0;
    runs_if.ready        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Short run on the reset configuration.
    idle_pct = 20;
    fill_random(60);
    wait_drained();

    // Directed bytes on an over-wide, two-line frame.
    reg_write(RegLineWidth, 11'd2047);
    reg_write(RegFrameHeight, 11'd2);
    put(1'b1, 1'b0, 8'hFF);
    // Key chunk: a two-byte literal and the longest key repeat, then an empty last line.
    begin_chunk(1'b0);
    put_body(8'd2);
    put_body(8'hFE);
    put_body(8'h00);
    put_body(8'hFF);
    put_body(8'h7F);
    put_body(8'hAA);
    put_body(8'h00);
    // Key chunk abandoned part way by a delta restart.
    begin_chunk(1'b0);
    put_body(8'd1);
    put_body(8'h81);
    // Delta chunk: largest line skip, which wraps the address, a repeat of 128,
    // then an empty repeat that finishes the chunk.
    begin_chunk(1'b1);
    put_body(8'hFF);
    put_body(8'hFF);
    put_body(8'h02);
    put_body(8'h00);
    put_body(8'h01);
    put_body(8'hFF);
    put_body(8'h80);
    put_body(8'h55);
    put_body(8'h01);
    put_body(8'h00);
    put_body(8'h00);
    put_body(8'h12);
    // Delta chunk with a negative line count.
    begin_chunk(1'b1);
    put_body(8'h00);
    put_body(8'h00);
    put_body(8'h00);
    put_body(8'h80);
    wait_drained();

    // Random phases over a spread of frame shapes; the last one runs without idling.
    run_phase(11'd1, 11'd1, $urandom_range(10, 40), 1'b0);
    run_phase(11'd1024, 11'd1024, $urandom_range(10, 40), 1'b1);
    run_phase(11'd0, 11'd3, 0, 1'b0);
    run_phase(11'd7, 11'd0, $urandom_range(10, 40), 1'b0);
    run_phase(11'd1024, 11'd4, $urandom_range(10, 40), 1'b0);
    run_phase(11'd13, 11'd2, 0, 1'b0);
    run_phase(11'd2047, 11'd2047, $urandom_range(10, 40), 1'b0);
    run_phase(11'd640, 11'd5, 0, 1'b0);
    repeat (10) @(negedge clk_i);

    $display("Covered %0d accepted bytes and %0d checked runs over ten frame settings.",
             bytes_accepted, runs_checked);
    $display("Of those runs, %0d closed a chunk and %0d reached past the frame.",
             dones_seen, outside_seen);
    if (fail_count == 0) begin
      $display("rle_frame_chunk_decoder test passed");
    end else begin
      $display("rle_frame_chunk_decoder test failed");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #2_000_000;
    $display("rle_frame_chunk_decoder test failed");
    $finish;
  end

endmodule
